// ===== hdl/ldfwg_pkg.sv =====
// Shared types and constants of the LFO wave generator with delay and fade-in.
// Holds the item, result and command types used by the controller and datapath.
// No dependencies.
package ldfwg_pkg;

  localparam int unsigned SINE_ENTRIES = 257;
  localparam int unsigned SINE_AW      = $clog2(SINE_ENTRIES);

  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 16;

  localparam logic [15:0] GLIDE_STEP = 16'h0050;
  localparam logic [13:0] RATE_MAX   = 14'h28F6;
  localparam logic [15:0] FADE_FULL  = 16'hFFFF;
  localparam logic [16:0] DELAY_END  = 17'h0FFFF;
  localparam logic [15:0] MID_CODE   = 16'h8000;
  localparam logic [15:0] QUARTER    = 16'h4000;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_WAVEFORM    = 2'd0;
  localparam logic [CFG_AW-1:0] REG_PHASE_START = 2'd1;
  localparam logic [CFG_AW-1:0] REG_DELAY_STEP  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_FADE_STEP   = 2'd3;

  // Waveform codes; codes above WAVE_GLIDE are illegal and hold the output.
  localparam logic [2:0] WAVE_SINE     = 3'd0;
  localparam logic [2:0] WAVE_SQUARE   = 3'd1;
  localparam logic [2:0] WAVE_SAWTOOTH = 3'd2;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
  localparam logic [2:0] WAVE_SAMPLE   = 3'd4;
  localparam logic [2:0] WAVE_GLIDE    = 3'd5;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_LOAD    = 2'd1,
    FUNC_RESTART = 2'd2
  } func_e;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] rate_request;
    logic [15:0]        random_word;
    logic [8:0]         table_index;
    logic [7:0]         table_data;
  } ldfwg_item_t;

  typedef struct packed {
    logic [15:0]        raw_value;
    logic signed [15:0] faded_value;
    logic               running;
  } ldfwg_res_t;

  typedef struct packed {
    logic start;    // tick accepted: advance delay, fade and phase, read table
    logic load;     // write one sine table entry
    logic restart;  // reload the phase accumulator
    logic wave;     // form the waveform value
    logic mul;      // multiply magnitude by fade level
    logic commit;   // divide, update held values, load output register
  } ldfwg_cmd_t;

endpackage

// ===== hdl/ldfwg_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Has no dependencies; its field widths mirror those of ldfwg_pkg.
interface ldfwg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [15:0] rate_request;
  logic [15:0]        random_word;
  logic [8:0]         table_index;
  logic [7:0]         table_data;

  modport source (output valid, func, rate_request, random_word, table_index, table_data,
                  input ready);
  modport sink (input valid, func, rate_request, random_word, table_index, table_data,
                output ready);
endinterface

interface ldfwg_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        raw_value;
  logic signed [15:0] faded_value;
  logic               running;

  modport source (output valid, raw_value, faded_value, running, input ready);
  modport sink (input valid, raw_value, faded_value, running, output ready);
endinterface

// ===== hdl/ldfwg_ctrl.sv =====
// Controller of the LFO wave generator: input/output handshake and tick sequencing.
// Depends on ldfwg_pkg.
module ldfwg_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [1:0]              in_func_i,
  output logic                    in_ready_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output ldfwg_pkg::ldfwg_cmd_t   cmd_o
);
  import ldfwg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WAVE = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_take;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_take     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          case (in_func_i)
            FUNC_TICK: begin
              cmd_o.start = 1'b1;
              state_d     = ST_WAVE;
            end
            FUNC_LOAD:    cmd_o.load    = 1'b1;
            FUNC_RESTART: cmd_o.restart = 1'b1;
            default: ;
          endcase
        end
      end
      ST_WAVE: begin
        cmd_o.wave = 1'b1;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        // The result waits here until the output register is free.
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/ldfwg_dp.sv =====
// Datapath of the LFO wave generator: configuration, oscillator state, sine
// table, waveform forming, fade scaling and output register. Depends on ldfwg_pkg.
module ldfwg_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ldfwg_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [ldfwg_pkg::CFG_DW-1:0] cfg_data_i,
  input  ldfwg_pkg::ldfwg_item_t      item_i,
  input  ldfwg_pkg::ldfwg_cmd_t       cmd_i,
  output ldfwg_pkg::ldfwg_res_t       res_o
);
  import ldfwg_pkg::*;

  // Configuration registers.
  logic [2:0]  wave_sel_q;
  logic [15:0] phase_start_q;
  logic [15:0] delay_step_q;
  logic [15:0] fade_step_q;

  // Oscillator state.
  logic [15:0] phase_q, phase_d;
  logic [16:0] delay_q, delay_d;
  logic [15:0] fade_q, fade_d;
  logic [15:0] held_rnd_q, held_rnd_d;
  logic        first_q, first_d;
  logic [15:0] raw_held_q;
  logic [15:0] faded_held_q;

  // Pipeline registers.
  logic [7:0]  tab_a_q, tab_b_q;
  logic [7:0]  frac_q;
  logic        run_q;
  logic [16:0] val_q;
  logic        neg_q;
  logic [15:0] mag_q;
  logic [31:0] prod_q;
  ldfwg_res_t  res_q;

  logic [7:0]  sine_mem [SINE_ENTRIES];

  // ---------------- tick start: delay, fade, phase, table read ----------------
  logic              delay_active;
  logic [16:0]       delay_sum;
  logic              running;
  logic [16:0]       fade_sum;
  logic [13:0]       rate;
  logic [15:0]       phase_add1;
  logic [16:0]       phase_add2;
  logic              wrap;
  logic [15:0]       sine_v;
  logic [SINE_AW-1:0] addr_a, addr_b;

  always_comb begin
    delay_active = (delay_q < DELAY_END);
    delay_sum    = delay_q + {1'b0, delay_step_q};
    running      = !delay_active || (delay_sum >= DELAY_END);
    fade_sum     = {1'b0, fade_q} + {1'b0, fade_step_q};

    if (item_i.rate_request[15]) begin
      rate = '0;
    end else if (item_i.rate_request[14:0] > {1'b0, RATE_MAX}) begin
      rate = RATE_MAX;
    end else begin
      rate = item_i.rate_request[13:0];
    end

    phase_add1 = phase_q + {2'b00, rate};
    phase_add2 = {1'b0, phase_q} + {2'b00, rate, 1'b0};
    wrap       = phase_add2[16];

    delay_d    = delay_active ? delay_sum : delay_q;
    fade_d     = fade_q;
    phase_d    = phase_q;
    held_rnd_d = held_rnd_q;
    first_d    = first_q;
    if (running) begin
      if (fade_q != FADE_FULL) begin
        fade_d = fade_sum[16] ? FADE_FULL : fade_sum[15:0];
      end
      case (wave_sel_q)
        WAVE_SINE, WAVE_SQUARE, WAVE_SAWTOOTH, WAVE_TRIANGLE: phase_d = phase_add1;
        WAVE_SAMPLE: begin
          phase_d = phase_add2[15:0];
          if (wrap) begin
            held_rnd_d = item_i.random_word;
          end
        end
        WAVE_GLIDE: begin
          phase_d = phase_add2[15:0];
          if (wrap || first_q) begin
            held_rnd_d = item_i.random_word;
            first_d    = 1'b0;
          end
        end
        default: ;
      endcase
    end

    // Distance from the half-way point selects two neighboring table entries.
    sine_v = phase_d[15] ? {1'b0, phase_d[14:0]} : (MID_CODE - phase_d);
    addr_a = {1'b0, sine_v[15:8]};
    addr_b = addr_a + 1'b1;
  end

  // Sine table: one write port, two registered read ports, no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && ({1'b0, item_i.table_index} < 10'(SINE_ENTRIES))) begin
      sine_mem[item_i.table_index] <= item_i.table_data;
    end
    if (cmd_i.start) begin
      tab_a_q <= sine_mem[addr_a];
      tab_b_q <= sine_mem[addr_b];
    end
  end

  // ---------------- waveform forming ----------------
  logic [16:0] sine_sum;
  logic [15:0] sine_pos;
  logic [15:0] sine_val;
  logic [14:0] tri_p;
  logic [14:0] tri_t;
  logic [15:0] tri_d;
  logic [16:0] tri_val;
  logic [16:0] glide_up;
  logic [16:0] tgt_up;
  logic [15:0] glide_val;
  logic [16:0] val;
  logic        neg;
  logic [15:0] mag;

  always_comb begin
    sine_sum = 17'(tab_a_q) * 17'(9'd256 - {1'b0, frac_q}) + 17'(tab_b_q) * 17'(frac_q);
    sine_pos = {1'b0, sine_sum[15:1]};
    sine_val = (phase_q > MID_CODE) ? (16'h0000 - sine_pos) : sine_pos;

    // Triangle: fold to the first half, measure from the quarter point.
    tri_p = phase_q[15] ? 15'(16'h0000 - phase_q) : phase_q[14:0];
    tri_t = (tri_p >= QUARTER[14:0]) ? (tri_p - QUARTER[14:0]) : (QUARTER[14:0] - tri_p);
    tri_d = {tri_t, 1'b0};
    if (phase_q == MID_CODE) begin
      tri_val = {1'b0, MID_CODE};
    end else if (!phase_q[15]) begin
      tri_val = (tri_t == '0) ? 17'h18000 : ({1'b0, MID_CODE} - {1'b0, tri_d});
    end else begin
      tri_val = (tri_t == '0) ? 17'h07FFF : ({1'b0, tri_d} - {1'b0, MID_CODE});
    end

    glide_up = {1'b0, raw_held_q} + {1'b0, GLIDE_STEP};
    tgt_up   = {1'b0, held_rnd_q} + {1'b0, GLIDE_STEP};
    if (raw_held_q == held_rnd_q) begin
      glide_val = raw_held_q;
    end else if (raw_held_q < held_rnd_q) begin
      glide_val = (glide_up < {1'b0, held_rnd_q}) ? glide_up[15:0] : held_rnd_q;
    end else begin
      glide_val = ({1'b0, raw_held_q} > tgt_up) ? (raw_held_q - GLIDE_STEP) : held_rnd_q;
    end

    case (wave_sel_q)
      WAVE_SINE:     val = {1'b0, sine_val};
      WAVE_SQUARE:   val = {1'b0, phase_q[15] ? 16'h8001 : 16'h7FFF};
      WAVE_SAWTOOTH: val = {1'b0, phase_q ^ MID_CODE};
      WAVE_TRIANGLE: val = tri_val;
      WAVE_SAMPLE:   val = {1'b0, held_rnd_q};
      WAVE_GLIDE:    val = {1'b0, glide_val};
      default:       val = '0;
    endcase

    // Signed magnitude for the fade: codes above the centre count down from 0xFFFF.
    if (val[16]) begin
      neg = 1'b1;
      mag = 16'(17'h00000 - val);
    end else if (val[15:0] == MID_CODE) begin
      neg = 1'b0;
      mag = '0;
    end else if (!val[15]) begin
      neg = 1'b0;
      mag = val[15:0];
    end else begin
      neg = 1'b1;
      mag = FADE_FULL - val[15:0];
    end
  end

  // ---------------- divide by 65535 and commit ----------------
  logic [15:0] quo0;
  logic [16:0] rem;
  logic [15:0] quo;
  logic [15:0] faded;
  logic        upd;

  always_comb begin
    quo0  = prod_q[31:16];
    rem   = {1'b0, prod_q[15:0]} + {1'b0, quo0};
    quo   = (rem >= {1'b0, FADE_FULL}) ? (quo0 + 16'd1) : quo0;
    faded = neg_q ? (16'h0000 - quo) : quo;
    upd   = run_q && (wave_sel_q <= WAVE_GLIDE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_sel_q    <= '0;
      phase_start_q <= '0;
      delay_step_q  <= '0;
      fade_step_q   <= '0;
      phase_q       <= '0;
      delay_q       <= '0;
      fade_q        <= '0;
      held_rnd_q    <= '0;
      first_q       <= 1'b1;
      raw_held_q    <= '0;
      faded_held_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WAVEFORM:    wave_sel_q    <= cfg_data_i[2:0];
          REG_PHASE_START: phase_start_q <= cfg_data_i;
          REG_DELAY_STEP:  delay_step_q  <= cfg_data_i;
          REG_FADE_STEP:   fade_step_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.restart) begin
        phase_q <= phase_start_q;
      end else if (cmd_i.start) begin
        phase_q <= phase_d;
      end
      if (cmd_i.start) begin
        delay_q    <= delay_d;
        fade_q     <= fade_d;
        held_rnd_q <= held_rnd_d;
        first_q    <= first_d;
      end
      if (cmd_i.commit && upd) begin
        raw_held_q   <= val_q[15:0];
        faded_held_q <= faded;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      frac_q <= sine_v[7:0];
      run_q  <= running;
    end
    if (cmd_i.wave) begin
      val_q <= val;
      neg_q <= neg;
      mag_q <= mag;
    end
    if (cmd_i.mul) begin
      prod_q <= mag_q * fade_q;
    end
    if (cmd_i.commit) begin
      res_q.raw_value   <= upd ? val_q[15:0] : raw_held_q;
      res_q.faded_value <= upd ? faded : faded_held_q;
      res_q.running     <= run_q;
    end
  end

  assign res_o = res_q;

endmodule

// ===== hdl/lfo_delay_fade_wave_generator.sv =====
// Top level of the LFO wave generator with delay and fade-in.
// Depends on ldfwg_pkg, ldfwg_if, ldfwg_ctrl and ldfwg_dp.
//
// This block is a low-frequency oscillator driven by tick items. Each tick
// clamps its rate request to 0..0x28F6, advances the delay counter and, once
// the delay is over, ramps the fade level and the 16-bit phase, then returns
// one result: the raw waveform word (0x8000 is the centre), the waveform
// scaled by fade/65535 truncated toward zero, and a running flag. Load items
// write one entry of the 257-entry sine table and restart items reload the
// phase from its start register; neither gives a result nor closes the input,
// so they can be sent in consecutive cycles. A tick closes the input until it
// is done: the accepting cycle updates the oscillator state and reads two
// neighboring sine entries through the table's two read ports, then the
// waveform is formed, its magnitude is multiplied by the fade level, and the
// product is divided by 65535 and written to the output register. The output
// register lets the next item be accepted while a result waits; a tick only
// stalls in its final state if the previous result has still not been taken.
// The sine table has no reset and no clearing pass: all 257 entries must be
// loaded before the sine waveform is selected. Configuration is written
// through a plain write port and must only change while idle.
module lfo_delay_fade_wave_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ldfwg_in_if.sink                     in_i,
  ldfwg_out_if.source                  out_o,
  input  logic                         cfg_we_i,
  input  logic [ldfwg_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [ldfwg_pkg::CFG_DW-1:0] cfg_data_i
);
  import ldfwg_pkg::*;

  ldfwg_item_t item;
  ldfwg_res_t  res;
  ldfwg_cmd_t  cmd;
  logic        in_ready;
  logic        out_valid;

  // Gather the input payload into one item word for the datapath.
  always_comb begin
    item.func         = in_i.func;
    item.rate_request = in_i.rate_request;
    item.random_word  = in_i.random_word;
    item.table_index  = in_i.table_index;
    item.table_data   = in_i.table_data;
  end

  ldfwg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_func_i   (in_i.func),
    .in_ready_o  (in_ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  ldfwg_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item),
    .cmd_i      (cmd),
    .res_o      (res)
  );

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid;
  assign out_o.raw_value   = res.raw_value;
  assign out_o.faded_value = res.faded_value;
  assign out_o.running     = res.running;

  // A tick transfer keeps the input closed through the waveform, multiply and final states.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.func == FUNC_TICK)
      |=> !in_i.ready ##1 !in_i.ready ##1 !in_i.ready)
    else $error("input reopened before the tick finished");

  // Load, restart and unused items complete in the cycle they are taken.
  a_short_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.func != FUNC_TICK) |=> in_i.ready)
    else $error("non-tick item held the input closed");

  // A result only appears when a tick commits it.
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.commit))
    else $error("result valid without a commit");

  // A committed result is always presented in the next cycle.
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_o.valid)
    else $error("committed result not presented");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the LFO wave generator with delay and fade-in.
// Sends table loads, restarts and ticks over the valid/ready channels and checks
// each result against an untimed model kept here; uses ldfwg_pkg and ldfwg_if.
module tb;
  import ldfwg_pkg::*;

  // Waveform codes above the glide code are illegal; func code 3 is unused.
  localparam logic [2:0] WAVE_BAD_LO = 3'd6;
  localparam logic [2:0] WAVE_BAD_HI = 3'd7;
  localparam logic [1:0] FUNC_SPARE  = 2'd3;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 5;
  localparam int IDLE_PCT       = 38;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 48;
  localparam int STEADY_PHASE   = 4;
  localparam int PRESSURE_PHASE = 2;
  localparam int HOLD_OFF       = 300;
  localparam int TIMEOUT_CYCLES = 200000;

  // Arithmetic constants of the oscillator as plain signed integers.
  localparam int HALF      = int'(MID_CODE);
  localparam int QUART     = int'(QUARTER);
  localparam int FULL      = int'(FADE_FULL);
  localparam int WRAP      = FULL + 1;
  localparam int WORD_MASK = FULL;
  localparam int RATE_TOP  = int'(RATE_MAX);
  localparam int GLIDE     = int'(GLIDE_STEP);

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_data;

  ldfwg_in_if  in_ch ();
  ldfwg_out_if out_ch ();

  lfo_delay_fade_wave_generator dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_ch.sink),
    .out_o     (out_ch.source),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // Configuration as the model sees it.
  logic [2:0]  wave_sel;
  logic [15:0] start_phase;
  logic [15:0] delay_inc;
  logic [15:0] fade_inc;

  // Oscillator state of the model. The delay counter and fade level get one
  // extra bit so that the overshoot past 0xFFFF is visible before the clamp.
  logic [15:0] phase;
  logic [16:0] delay_cnt;
  logic [16:0] fade_lvl;
  logic [15:0] rnd_hold;
  logic        first_draw;
  logic [15:0] raw_hold;
  logic [15:0] faded_hold;
  logic [7:0]  sine_rom [SINE_ENTRIES];

  // Results of accepted ticks that have not come out of the block yet.
  ldfwg_res_t lfo_words_due [$];

  bit no_idle;        // both sides stop idling while this is set
  int rx_hold_cycles; // the receiver keeps ready low for this many cycles
  int fault_count;
  int mismatch_count;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Adds an increment to the phase accumulator and tells whether it wrapped.
  function automatic bit step_phase(int inc);
    int total;
    total = int'(phase) + inc;
    phase = total[15:0];
    return total[16];
  endfunction

  // The sine table holds one quarter wave of magnitudes. The distance of the
  // phase from the centre selects two neighbors, which are interpolated by the
  // low byte; the half above the centre is mirrored to negative codes.
  function automatic int sine_word();
    int ph, span, idx, frac, lo, hi, r;
    ph   = phase;
    span = (ph >= HALF) ? ph - HALF : HALF - ph;
    idx  = (span >> 8) & 255;
    frac = span & 255;
    lo   = sine_rom[idx];
    hi   = sine_rom[idx + 1];
    r    = ((lo * (256 - frac) + hi * frac) & WORD_MASK) >> 1;
    if (ph > HALF) r = (WRAP - r) & WORD_MASK;
    return r;
  endfunction

  // The triangle folds each half of the cycle around the quarter point. In the
  // lower half the result can drop below zero; at the quarter point it is
  // -0x8000, which the fade scaling then takes as a full negative swing.
  function automatic int triangle_word();
    int ph, fold, slope, twice;
    ph = phase;
    if (ph == HALF) return HALF;
    fold  = (ph < HALF) ? ph : WRAP - ph;
    slope = (fold >= QUART) ? QUART - fold : fold - QUART;
    twice = (2 * slope) & WORD_MASK;
    if (ph < HALF) return twice - HALF;
    return (twice == 0) ? HALF - 1 : HALF - twice;
  endfunction

  // Random glide walks from the last output toward a held random target. The
  // phase always advances at twice the rate; a new target is drawn on a wrap
  // and on the very first glide tick after reset.
  function automatic int glide_word(int rate, logic [15:0] draw);
    int cur, goal;
    cur = raw_hold;
    if (step_phase(2 * rate) || first_draw) begin
      first_draw = 1'b0;
      rnd_hold   = draw;
    end
    goal = rnd_hold;
    if (cur < goal) return (cur + GLIDE < goal) ? cur + GLIDE : goal;
    if (cur > goal) return (cur - GLIDE > goal) ? cur - GLIDE : goal;
    return cur;
  endfunction

  // Scales a waveform code by fade/65535. Codes above the centre are negative
  // and measured from 0xFFFF; the quotient is truncated toward zero.
  function automatic logic [15:0] scale_by_fade(int word);
    longint sgn_word, mag, quot;
    if (word == HALF) return '0;
    sgn_word = (word < HALF) ? word : word - FULL;
    mag      = (sgn_word < 0) ? -sgn_word : sgn_word;
    quot     = (mag * longint'(fade_lvl)) / FULL;
    if (sgn_word < 0) quot = -quot;
    return quot[15:0];
  endfunction

  // Works out the result of one tick and moves the model state along.
  function automatic ldfwg_res_t lfo_tick(ldfwg_item_t it);
    ldfwg_res_t res;
    int         rate;
    int         word;
    bit         live;
    bit         legal;
    live  = 1'b1;
    legal = 1'b1;
    word  = 0;
    // The delay counter stops counting once it has reached 0xFFFF.
    if (delay_cnt < DELAY_END) begin
      delay_cnt = delay_cnt + delay_inc;
      if (delay_cnt < DELAY_END) live = 1'b0;
    end
    if (live) begin
      if (fade_lvl < FULL) begin
        fade_lvl = fade_lvl + fade_inc;
        if (fade_lvl > FULL) fade_lvl = FULL;
      end
      if (it.rate_request[15]) rate = 0;
      else if (int'(it.rate_request) > RATE_TOP) rate = RATE_TOP;
      else rate = int'(it.rate_request);
      case (wave_sel)
        WAVE_SINE: begin
          void'(step_phase(rate));
          word = sine_word();
        end
        WAVE_SQUARE: begin
          void'(step_phase(rate));
          word = (phase < MID_CODE) ? HALF - 1 : HALF + 1;
        end
        WAVE_SAWTOOTH: begin
          void'(step_phase(rate));
          word = (int'(phase) - HALF) & WORD_MASK;
        end
        WAVE_TRIANGLE: begin
          void'(step_phase(rate));
          word = triangle_word();
        end
        WAVE_SAMPLE: begin
          if (step_phase(2 * rate)) rnd_hold = it.random_word;
          word = rnd_hold;
        end
        WAVE_GLIDE: word = glide_word(rate, it.random_word);
        // An illegal waveform freezes the phase and repeats the held output.
        default: legal = 1'b0;
      endcase
      if (legal) begin
        raw_hold   = word[15:0];
        faded_hold = scale_by_fade(word);
      end
    end
    res.raw_value   = raw_hold;
    res.faded_value = faded_hold;
    res.running     = live;
    return res;
  endfunction

  // Applies one accepted item to the model. Only ticks give a result.
  function automatic void model_item(ldfwg_item_t it);
    case (it.func)
      FUNC_LOAD: begin
        if (it.table_index < SINE_ENTRIES) sine_rom[it.table_index] = it.table_data;
      end
      FUNC_RESTART: phase = start_phase;
      FUNC_TICK:    lfo_words_due.push_back(lfo_tick(it));
      default: ;
    endcase
  endfunction

  // Item with random content in every field, so that the fields an operation
  // does not use still toggle.
  function automatic ldfwg_item_t scrambled_item(logic [1:0] code);
    ldfwg_item_t it;
    it.func         = code;
    it.rate_request = 16'($urandom);
    it.random_word  = 16'($urandom);
    it.table_index  = 9'($urandom);
    it.table_data   = 8'($urandom);
    return it;
  endfunction

  // Offers one item and waits for its transfer. Valid stays high afterwards so
  // that a following item can be offered back to back; the random idle cycles
  // in front of the item are where the sender drops valid.
  task automatic send_item(ldfwg_item_t it);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= it.func;
    in_ch.rate_request <= it.rate_request;
    in_ch.random_word  <= it.random_word;
    in_ch.table_index  <= it.table_index;
    in_ch.table_data   <= it.table_data;
    do @(posedge clk); while (!in_ch.ready);
    model_item(it);
  endtask

  task automatic send_tick(logic signed [15:0] rate);
    ldfwg_item_t it;
    it = scrambled_item(FUNC_TICK);
    it.rate_request = rate;
    send_item(it);
  endtask

  task automatic send_load(logic [8:0] idx, logic [7:0] data);
    ldfwg_item_t it;
    it = scrambled_item(FUNC_LOAD);
    it.table_index = idx;
    it.table_data  = data;
    send_item(it);
  endtask

  task automatic send_func(logic [1:0] code);
    send_item(scrambled_item(code));
  endtask

  // Stops offering items and waits until every pending tick has come out.
  // Loads and restarts give nothing back, so a further settling wait lets the
  // last of them finish before the configuration is touched.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (lfo_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_WAVEFORM:    wave_sel    = data[2:0];
      REG_PHASE_START: start_phase = data;
      REG_DELAY_STEP:  delay_inc   = data;
      REG_FADE_STEP:   fade_inc    = data;
      default: ;
    endcase
  endtask

  // Rewrites all four registers once the block has gone quiet.
  task automatic set_lfo(logic [2:0] wave, logic [15:0] start, logic [15:0] dly,
                         logic [15:0] fade);
    settle();
    write_reg(REG_WAVEFORM, {13'b0, wave});
    write_reg(REG_PHASE_START, start);
    write_reg(REG_DELAY_STEP, dly);
    write_reg(REG_FADE_STEP, fade);
  endtask

  // The table has no reset, so every entry is loaded before the first tick.
  // The first and last entries take the extreme data values. Loads past the
  // end of the table and the unused func code must be ignored.
  task automatic test_table_fill();
    logic [7:0] data;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      if (i == 0) data = 8'h00;
      else if (i == SINE_ENTRIES - 1) data = 8'hFF;
      else data = 8'($urandom);
      send_load(9'(i), data);
    end
    send_load(9'(SINE_ENTRIES), 8'hA5);
    send_load(9'h1FF, 8'h5A);
    send_func(FUNC_SPARE);
  endtask

  // With a zero delay step the block never leaves the delay phase. Then a
  // step of 0x5555 ends the delay on the third tick, when the counter lands
  // exactly on 0xFFFF; a restart in between only reloads the phase.
  task automatic test_delay_phase();
    send_tick(16'sh8000);
    send_tick(16'sh7FFF);
    set_lfo(WAVE_SAWTOOTH, 16'h2000, 16'h5555, 16'h0300);
    send_tick(16'h0100);
    send_func(FUNC_RESTART);
    send_tick(16'h0100);
    send_tick(16'h0100);
    send_tick(16'h0000);
  endtask

  // Every waveform code, the illegal ones too, from a restart: one tick just
  // above the rate ceiling and one at the most negative rate, which clamps to
  // zero. The sample start sits close to the top so that the doubled rate
  // wraps and draws a new sample; the glide tick is the first after reset.
  task automatic test_waveforms();
    logic [15:0] start;
    for (int w = 0; w <= int'(WAVE_BAD_HI); w++) begin
      start = (w == int'(WAVE_SAMPLE)) ? 16'hF000 : {4'(w * 3 + 7), 12'h000};
      set_lfo(3'(w), start, 16'hFFFF, 16'h0300);
      send_func(FUNC_RESTART);
      send_tick(16'h28F7);
      send_tick(16'sh8000);
    end
  endtask

  // Random phases, each under its own register setting. Most items are ticks
  // with rates spread over the legal range, the ceiling and the whole signed
  // word; restarts and table rewrites are mixed in, and ignored items are not
  // counted. One phase runs without any idling, and in another the receiver
  // holds off for a long stretch while the sender keeps offering ticks.
  task automatic test_random_phases();
    int                 done;
    int                 pick;
    bit                 squeezed;
    logic [2:0]         wave;
    logic [15:0]        start;
    logic [15:0]        dly;
    logic [15:0]        fade;
    logic signed [15:0] rate;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if ($urandom_range(99) < 85) wave = 3'($urandom_range(int'(WAVE_GLIDE)));
      else wave = 3'($urandom_range(int'(WAVE_BAD_HI), int'(WAVE_BAD_LO)));
      if ($urandom_range(1)) start = {4'($urandom_range(15)), 12'h000};
      else start = 16'($urandom);
      dly  = 16'($urandom);
      fade = (ph < 3) ? 16'($urandom_range(512, 1)) : 16'($urandom);
      if (ph == 0) begin
        start = 16'hFFFF;
        dly   = 16'hFFFF;
      end
      if (ph == 1) begin
        start = 16'h0000;
        dly   = 16'h0000;
        fade  = 16'h0000;
      end
      set_lfo(wave, start, dly, fade);
      no_idle  = (ph == STEADY_PHASE);
      squeezed = 1'b0;
      done     = 0;
      while (done < PHASE_ITEMS) begin
        if (ph == PRESSURE_PHASE && done == 10 && !squeezed) begin
          rx_hold_cycles = HOLD_OFF;
          squeezed       = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 78) begin
          case ($urandom_range(5))
            0, 1:    rate = 16'($urandom_range(RATE_TOP));
            2:       rate = 16'($urandom_range(RATE_TOP + 8, RATE_TOP - 8));
            3:       rate = 16'($urandom_range(255));
            default: rate = 16'($urandom);
          endcase
          send_tick(rate);
          done++;
        end else if (pick < 86) begin
          send_func(FUNC_RESTART);
          done++;
        end else if (pick < 94) begin
          send_load(9'($urandom_range(SINE_ENTRIES - 1)), 8'($urandom));
          done++;
        end else if (pick < 97) begin
          send_load(9'($urandom_range(511, SINE_ENTRIES)), 8'($urandom));
        end else begin
          send_func(FUNC_SPARE);
        end
      end
      no_idle = 1'b0;
    end
  endtask

  // The triangle at its quarter point, where a full fade gives -32768, and at
  // the centre, which scales to zero.
  task automatic test_triangle_floor();
    set_lfo(WAVE_TRIANGLE, QUARTER, 16'h0000, 16'hFFFF);
    send_func(FUNC_RESTART);
    send_tick(16'h0000);
    send_tick(16'sh8000);
    set_lfo(WAVE_TRIANGLE, MID_CODE, 16'h0000, 16'hFFFF);
    send_func(FUNC_RESTART);
    send_tick(16'h0000);
  endtask

  // Receiver: takes results at random, or always while no_idle is set, and
  // holds off completely while a hold-off count is pending.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        out_ch.ready   <= 1'b0;
        rx_hold_cycles -= 1;
      end else if (no_idle) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Every result transfer is matched against the oldest pending tick.
  always @(posedge clk) begin : result_check
    ldfwg_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (lfo_words_due.size() == 0) begin
        fault_count++;
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("result with no pending tick: raw %h faded %0d running %b",
                   out_ch.raw_value, out_ch.faded_value, out_ch.running);
      end else begin
        want = lfo_words_due.pop_front();
        if (out_ch.raw_value !== want.raw_value || out_ch.faded_value !== want.faded_value ||
            out_ch.running !== want.running) begin
          fault_count++;
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at %0t: raw %h/%h faded %0d/%0d running %b/%b (exp/act)",
                     $realtime, want.raw_value, out_ch.raw_value, want.faded_value,
                     out_ch.faded_value, want.running, out_ch.running);
        end
      end
    end
  end

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= '0;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FUNC_TICK;
    in_ch.rate_request <= '0;
    in_ch.random_word  <= '0;
    in_ch.table_index  <= '0;
    in_ch.table_data   <= '0;
    no_idle        = 1'b0;
    rx_hold_cycles = 0;
    fault_count    = 0;
    mismatch_count = 0;
    // Model state after reset.
    wave_sel    = WAVE_SINE;
    start_phase = '0;
    delay_inc   = '0;
    fade_inc    = '0;
    phase       = '0;
    delay_cnt   = '0;
    fade_lvl    = '0;
    rnd_hold    = '0;
    first_draw  = 1'b1;
    raw_hold    = '0;
    faded_hold  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_fill();
    test_delay_phase();
    test_waveforms();
    test_random_phases();
    test_triangle_floor();
    settle();

    if (fault_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== lfo_delay_fade_wave_generator.f =====
hdl/ldfwg_pkg.sv
hdl/ldfwg_if.sv
hdl/ldfwg_ctrl.sv
hdl/ldfwg_dp.sv
hdl/lfo_delay_fade_wave_generator.sv
tb/sv/tb.sv
